// ===== src/gwwb_pkg.sv =====
// Shared types and constants for the gray-world white balance gain estimator.
package gwwb_pkg;

    localparam int PIX_W      = 8;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] CFG_LOW_THRESHOLD  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHANGE     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SUBSAMPLE_STEP = 2'd3;

    typedef enum logic {
        CHAN_RED,
        CHAN_BLUE
    } t_chan;

    typedef struct packed {
        logic  load;
        logic  iter;
        logic  finish;
        logic  clear;
        logic  publish;
        t_chan chan;
    } t_dp_cmd;

endpackage

// ===== src/gwwb_ctrl.sv =====
// Controller: frame-end sequencing of the shared divider and the output register.
module gwwb_ctrl
    import gwwb_pkg::*;
#(
    parameter int GAIN_FRACTION_BITS = 14
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_take,
    input  logic    i_frame_end,
    input  logic    i_out_ready,
    output logic    o_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    localparam int CNT_W = $clog2(GAIN_FRACTION_BITS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_ITER,
        S_FINISH,
        S_PUBLISH
    } t_state;

    t_state           r_state,     n_state;
    t_chan            r_chan,      n_chan;
    logic [CNT_W-1:0] r_count,     n_count;
    logic             r_out_valid, n_out_valid;

    always_comb begin
        n_state     = r_state;
        n_chan      = r_chan;
        n_count     = r_count;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_cmd.chan  = r_chan;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_take && i_frame_end) begin
                    n_state = S_LOAD;
                    n_chan  = CHAN_RED;
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_count    = '0;
                n_state    = S_ITER;
            end
            S_ITER: begin
                o_cmd.iter = 1'b1;
                n_count    = r_count + CNT_W'(1);
                if (r_count == CNT_W'(GAIN_FRACTION_BITS)) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.finish = 1'b1;
                if (r_chan == CHAN_RED) begin
                    n_chan  = CHAN_BLUE;
                    n_state = S_LOAD;
                end else begin
                    o_cmd.clear = 1'b1;
                    n_state     = S_PUBLISH;
                end
            end
            S_PUBLISH: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.publish = 1'b1;
                    n_out_valid   = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_chan      <= CHAN_RED;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_chan      <= n_chan;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_ready     = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    a_frame_end_starts_red: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && i_frame_end) |=> (r_state == S_LOAD && r_chan == CHAN_RED))
        else $error("frame end did not start the red division");

    a_iter_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ITER) |-> (r_count <= CNT_W'(GAIN_FRACTION_BITS)))
        else $error("divider step count overran");

    a_valid_from_publish: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_PUBLISH))
        else $error("result raised outside publish");

endmodule

// ===== src/gwwb_dp.sv =====
// Datapath: settings, pixel accumulation, shared serial divider and gain registers.
module gwwb_dp
    import gwwb_pkg::*;
#(
    parameter int SUM_WIDTH          = 40,
    parameter int GAIN_FRACTION_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_take,
    input  logic [PIX_W-1:0]      i_red,
    input  logic [PIX_W-1:0]      i_green,
    input  logic [PIX_W-1:0]      i_blue,
    input  logic                  i_row_end,
    input  logic                  i_frame_end,
    input  t_dp_cmd               i_cmd,
    output logic [GAIN_W-1:0]     o_gain_red,
    output logic [GAIN_W-1:0]     o_gain_blue
);

    localparam int SW = SUM_WIDTH;
    localparam int GW = GAIN_FRACTION_BITS + 2;

    typedef enum logic [1:0] {
        SP_NONE,
        SP_ONE,
        SP_HIGH
    } t_special;

    logic [PIX_W-1:0]      r_low_threshold;
    logic [PIX_W-1:0]      r_high_threshold;
    logic [CFG_DATA_W-1:0] r_max_change;
    logic [PIX_W-1:0]      r_subsample_step;

    logic [SW-1:0]    r_sum_red, r_sum_green, r_sum_blue;
    logic [PIX_W-1:0] r_col_phase, r_row_phase;

    logic [SW-1:0] r_rem, r_den;
    logic [GW-1:0] r_quo;
    t_special      r_special;

    logic [GW-1:0]     r_stage_red, r_stage_blue;
    logic [GAIN_W-1:0] r_gain_red,  r_gain_blue;

    function automatic logic [SW-1:0] sat_add(input logic [SW-1:0] acc,
                                              input logic [PIX_W-1:0] v);
        logic [SW:0] s;
        s = {1'b0, acc} + (SW + 1)'(v);
        return s[SW] ? {SW{1'b1}} : s[SW-1:0];
    endfunction

    function automatic logic in_range(input logic [PIX_W-1:0] c,
                                      input logic [PIX_W-1:0] lo,
                                      input logic [PIX_W-1:0] hi);
        return (c >= lo) && (c <= hi);
    endfunction

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low_threshold  <= PIX_W'(15);
            r_high_threshold <= PIX_W'(240);
            r_max_change     <= CFG_DATA_W'(64);
            r_subsample_step <= PIX_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_LOW_THRESHOLD:  r_low_threshold  <= i_cfg_data[PIX_W-1:0];
                CFG_HIGH_THRESHOLD: r_high_threshold <= i_cfg_data[PIX_W-1:0];
                CFG_MAX_CHANGE:     r_max_change     <= i_cfg_data;
                CFG_SUBSAMPLE_STEP: r_subsample_step <= i_cfg_data[PIX_W-1:0];
                default: ;
            endcase
        end
    end

    // Subsampling phases and accumulation
    logic [PIX_W-1:0] step_eff;
    logic [PIX_W-1:0] col_adv, row_adv;
    logic [PIX_W:0]   col_inc, row_inc;
    logic             keep, count_all, exposed, add_pixel;

    always_comb begin
        step_eff  = (r_subsample_step == '0) ? PIX_W'(1) : r_subsample_step;
        col_inc   = {1'b0, r_col_phase} + (PIX_W + 1)'(1);
        row_inc   = {1'b0, r_row_phase} + (PIX_W + 1)'(1);
        col_adv   = (col_inc >= {1'b0, step_eff}) ? '0 : col_inc[PIX_W-1:0];
        row_adv   = (row_inc >= {1'b0, step_eff}) ? '0 : row_inc[PIX_W-1:0];
        keep      = (r_col_phase == '0) && (r_row_phase == '0);
        count_all = (r_low_threshold == '0) && (r_high_threshold == '0);
        exposed   = in_range(i_red,   r_low_threshold, r_high_threshold)
                 && in_range(i_green, r_low_threshold, r_high_threshold)
                 && in_range(i_blue,  r_low_threshold, r_high_threshold);
        add_pixel = i_take && keep && (count_all || exposed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum_red   <= '0;
            r_sum_green <= '0;
            r_sum_blue  <= '0;
            r_col_phase <= '0;
            r_row_phase <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_sum_red   <= '0;
                r_sum_green <= '0;
                r_sum_blue  <= '0;
            end else if (add_pixel) begin
                r_sum_red   <= sat_add(r_sum_red,   i_red);
                r_sum_green <= sat_add(r_sum_green, i_green);
                r_sum_blue  <= sat_add(r_sum_blue,  i_blue);
            end
            if (i_take) begin
                if (i_frame_end) begin
                    r_col_phase <= '0;
                    r_row_phase <= '0;
                end else if (i_row_end) begin
                    r_col_phase <= '0;
                    r_row_phase <= row_adv;
                end else begin
                    r_col_phase <= col_adv;
                end
            end
        end
    end

    // Shared restoring divider, one quotient bit per cycle
    logic [SW-1:0] num, den;
    logic [SW:0]   shifted, den_ext;
    logic          num_ge_den, num_ge_2den;

    always_comb begin
        num         = r_sum_green;
        den         = (i_cmd.chan == CHAN_BLUE) ? r_sum_blue : r_sum_red;
        num_ge_den  = (num >= den);
        num_ge_2den = ({1'b0, num} >= {den, 1'b0});
        shifted     = {r_rem, 1'b0};
        den_ext     = {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_den <= den;
            r_rem <= num_ge_den ? (num - den) : num;
            r_quo <= GW'(num_ge_den);
            if (den == '0) begin
                r_special <= SP_ONE;
            end else if (num_ge_2den) begin
                r_special <= SP_HIGH;
            end else begin
                r_special <= SP_NONE;
            end
        end else if (i_cmd.iter) begin
            if (shifted >= den_ext) begin
                r_rem <= SW'(shifted - den_ext);
                r_quo <= {r_quo[GW-2:0], 1'b1};
            end else begin
                r_rem <= shifted[SW-1:0];
                r_quo <= {r_quo[GW-2:0], 1'b0};
            end
        end
    end

    // Rounding and clamping to one plus or minus the allowed change
    logic [CFG_DATA_W-1:0] mc;
    logic [GW-1:0]         one, delta, lim_lo, lim_hi, rounded, gain;
    logic [GW:0]           quo_inc;

    always_comb begin
        mc      = (r_max_change > CFG_DATA_W'(256)) ? CFG_DATA_W'(256) : r_max_change;
        one     = GW'(1) << GAIN_FRACTION_BITS;
        delta   = GW'(mc) << (GAIN_FRACTION_BITS - 8);
        lim_lo  = one - delta;
        lim_hi  = one + delta;
        quo_inc = {1'b0, r_quo} + (GW + 1)'(1);
        rounded = quo_inc[GW:1];
        case (r_special)
            SP_ONE:  gain = one;
            SP_HIGH: gain = lim_hi;
            default: gain = rounded;
        endcase
        if (gain < lim_lo) begin
            gain = lim_lo;
        end
        if (gain > lim_hi) begin
            gain = lim_hi;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (i_cmd.chan == CHAN_BLUE) begin
                r_stage_blue <= gain;
            end else begin
                r_stage_red  <= gain;
            end
        end
    end

    // Output register, loaded only once the previous result is gone
    logic [GW+GAIN_W-1:0] ext_red, ext_blue;

    always_comb begin
        ext_red  = {{GAIN_W{1'b0}}, r_stage_red};
        ext_blue = {{GAIN_W{1'b0}}, r_stage_blue};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_gain_red  <= ext_red[GAIN_W-1:0];
            r_gain_blue <= ext_blue[GAIN_W-1:0];
        end
    end

    assign o_gain_red  = r_gain_red;
    assign o_gain_blue = r_gain_blue;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.iter && r_special == SP_NONE) |-> (r_rem < r_den))
        else $error("divider remainder not below divisor");

    a_clear_empties_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear |=> (r_sum_red == '0 && r_sum_green == '0 && r_sum_blue == '0))
        else $error("sums not cleared after frame");

endmodule

// ===== src/gray_world_white_balance_gains.sv =====
// Top level of the gray-world white balance gain estimator.
// Usage:
//   Slave stream: one RGB pixel per transfer, tdata = {blue, green, red} (red lowest),
//   tlast marks the last pixel of a row, tuser marks the last pixel of a frame.
//   Every subsample-step-th column and row is kept; kept pixels whose channels all
//   lie within the thresholds (or all pixels when both thresholds are zero) add
//   to saturating per-channel sums.
//   Master stream: one transfer per frame, tdata = {gain_blue, gain_red} (red lowest),
//   each unsigned with GAIN_FRACTION_BITS fraction bits, clamped to 1 +/- max_change/256.
//   Configuration: write i_cfg_data to register i_cfg_index when i_cfg_we is high
//   (0 low threshold, 1 high threshold, 2 max change, 3 subsample step); write only idle.
// Flow control:
//   Pixels are taken one per cycle while tready is high. The end-of-frame pixel starts
//   a shared one-bit-per-cycle divider that runs red then blue, each division being
//   loaded, iterated and finished in turn; the gains are then published to the output
//   register, and tready is low meanwhile.
// Reset (synchronous, active low) restores the register defaults, clears sums and
// phases and drops any pending result. When the receiver stalls the result holds in
// the output register; pixels keep flowing until the next frame end, whose gains then wait.
module gray_world_white_balance_gains
    import gwwb_pkg::*;
#(
    parameter int SUM_WIDTH          = 40,
    parameter int GAIN_FRACTION_BITS = 14
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [3*PIX_W-1:0]    i_s_axis_tdata,   // red, green, blue
    input  logic                  i_s_axis_tlast,   // row_end
    input  logic                  i_s_axis_tuser,   // frame_end
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [2*GAIN_W-1:0]   o_m_axis_tdata,   // gain_red, gain_blue
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_dp_cmd           cmd;
    logic              ready;
    logic              take;
    logic [GAIN_W-1:0] gain_red, gain_blue;

    // A pixel transfer completes only while the divider is idle
    assign take            = i_s_axis_tvalid && ready;
    assign o_s_axis_tready = ready;

    gwwb_ctrl #(
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_frame_end (i_s_axis_tuser),
        .i_out_ready (i_m_axis_tready),
        .o_ready     (ready),
        .o_out_valid (o_m_axis_tvalid),
        .o_cmd       (cmd)
    );

    gwwb_dp #(
        .SUM_WIDTH         (SUM_WIDTH),
        .GAIN_FRACTION_BITS(GAIN_FRACTION_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_take      (take),
        .i_red       (i_s_axis_tdata[PIX_W-1:0]),
        .i_green     (i_s_axis_tdata[2*PIX_W-1:PIX_W]),
        .i_blue      (i_s_axis_tdata[3*PIX_W-1:2*PIX_W]),
        .i_row_end   (i_s_axis_tlast),
        .i_frame_end (i_s_axis_tuser),
        .i_cmd       (cmd),
        .o_gain_red  (gain_red),
        .o_gain_blue (gain_blue)
    );

    assign o_m_axis_tdata = {gain_blue, gain_red};

endmodule
